### hdl/msk_pkg.sv
// Package for the modem socket keeper: codes, register map and the
// structs passed between the register file, the state engine and the top.
// No dependencies.
`timescale 1ns / 1ps

package msk_pkg;

  // Event codes
  localparam logic [2:0] OP_POLL          = 3'd0;
  localparam logic [2:0] OP_CREATE_REPLY  = 3'd1;
  localparam logic [2:0] OP_CONNECT_REPLY = 3'd2;
  localparam logic [2:0] OP_SOCK_STATUS   = 3'd3;
  localparam logic [2:0] OP_CLOSE_REPLY   = 3'd4;
  localparam logic [2:0] OP_MODEM_STATUS  = 3'd5;
  localparam logic [2:0] OP_AI_REPLY      = 3'd6;
  localparam logic [2:0] OP_RECONNECT     = 3'd7;

  // Socket phases
  localparam logic [2:0] PH_READY        = 3'd0;
  localparam logic [2:0] PH_CREATE_WAIT  = 3'd1;
  localparam logic [2:0] PH_CONNECT      = 3'd2;
  localparam logic [2:0] PH_CONNECT_WAIT = 3'd3;
  localparam logic [2:0] PH_CLOSE        = 3'd4;
  localparam logic [2:0] PH_CLOSE_WAIT   = 3'd5;

  // Frame kinds
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_CREATE  = 2'd1;
  localparam logic [1:0] KIND_CONNECT = 2'd2;
  localparam logic [1:0] KIND_CLOSE   = 2'd3;

  localparam logic [7:0] CREATE_ID = 8'd75;  // 'K'
  localparam logic [7:0] OTHER_ID  = 8'd1;

  // Register indexes (byte address is 4 * index)
  localparam int          ADDR_W             = 5;
  localparam logic [2:0]  REG_SERVER_PORT    = 3'd0;
  localparam logic [2:0]  REG_SOCKET_PROTO   = 3'd1;
  localparam logic [2:0]  REG_HOST_LENGTH    = 3'd2;
  localparam logic [2:0]  REG_CREATE_SIZE    = 3'd3;
  localparam logic [2:0]  REG_CONNECT_SIZE   = 3'd4;
  localparam logic [2:0]  REG_CLOSE_SIZE     = 3'd5;
  localparam logic [2:0]  REG_RETRY_INTERVAL = 3'd6;

  localparam logic [15:0] RETRY_RESET = 16'd3000;

  typedef struct packed {
    logic [15:0] server_port;
    logic [7:0]  socket_protocol;
    logic [7:0]  host_length;
    logic [7:0]  create_frame_size;
    logic [8:0]  connect_frame_size;
    logic [7:0]  close_frame_size;
    logic [15:0] retry_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  reply_frame_id;
    logic [7:0]  socket_number;
    logic        status_good;
    logic        command_is_ai;
    logic [7:0]  extra_length;
    logic [7:0]  assoc_byte;
    logic [15:0] free_space;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic        frame_valid;
    logic [1:0]  frame_kind;
    logic [7:0]  out_frame_id;
    logic [7:0]  out_socket;
    logic [15:0] out_port;
    logic [7:0]  out_protocol;
    logic        socket_usable;
    logic [7:0]  usable_socket;
    logic        network_is_up;
  } result_t;

endpackage

### hdl/msk_regs.sv
// Configuration register file for the modem socket keeper, APB-style port.
// Depends on msk_pkg.
`timescale 1ns / 1ps

module msk_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [msk_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output msk_pkg::cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= {16'd0, 8'd0, 8'd0, 8'd0, 9'd0, 8'd0, msk_pkg::RETRY_RESET};
    end else if (wr_en) begin
      case (idx)
        msk_pkg::REG_SERVER_PORT:    cfg.server_port        <= pwdata[15:0];
        msk_pkg::REG_SOCKET_PROTO:   cfg.socket_protocol    <= pwdata[7:0];
        msk_pkg::REG_HOST_LENGTH:    cfg.host_length        <= pwdata[7:0];
        msk_pkg::REG_CREATE_SIZE:    cfg.create_frame_size  <= pwdata[7:0];
        msk_pkg::REG_CONNECT_SIZE:   cfg.connect_frame_size <= pwdata[8:0];
        msk_pkg::REG_CLOSE_SIZE:     cfg.close_frame_size   <= pwdata[7:0];
        msk_pkg::REG_RETRY_INTERVAL: cfg.retry_interval_ms  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      msk_pkg::REG_SERVER_PORT:    prdata = {16'd0, cfg.server_port};
      msk_pkg::REG_SOCKET_PROTO:   prdata = {24'd0, cfg.socket_protocol};
      msk_pkg::REG_HOST_LENGTH:    prdata = {24'd0, cfg.host_length};
      msk_pkg::REG_CREATE_SIZE:    prdata = {24'd0, cfg.create_frame_size};
      msk_pkg::REG_CONNECT_SIZE:   prdata = {23'd0, cfg.connect_frame_size};
      msk_pkg::REG_CLOSE_SIZE:     prdata = {24'd0, cfg.close_frame_size};
      msk_pkg::REG_RETRY_INTERVAL: prdata = {16'd0, cfg.retry_interval_ms};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

### hdl/msk_engine.sv
// Socket state engine: holds phase, held socket, network flag and retry
// deadline, and works out one result per event. Depends on msk_pkg.
`timescale 1ns / 1ps

module msk_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  msk_pkg::item_t   item,
  input  msk_pkg::cfg_t    cfg,
  output msk_pkg::result_t res
);

  logic [2:0]  phase, phase_next;
  logic        socket_held, socket_held_next;
  logic [7:0]  held_socket, held_socket_next;
  logic        network_flag, network_flag_next;
  logic [31:0] retry_deadline, retry_deadline_next;
  logic        held_match;
  logic        usable;

  assign held_match = socket_held && (held_socket == item.socket_number);

  always_comb begin
    phase_next          = phase;
    socket_held_next    = socket_held;
    held_socket_next    = held_socket;
    network_flag_next   = network_flag;
    retry_deadline_next = retry_deadline;
    res                 = '0;

    case (item.opcode)
      msk_pkg::OP_POLL: begin
        if (phase == msk_pkg::PH_READY) begin
          if (!socket_held && network_flag &&
              item.free_space >= {8'd0, cfg.create_frame_size} &&
              item.now_ms > retry_deadline) begin
            retry_deadline_next = item.now_ms + {16'd0, cfg.retry_interval_ms};
            res.frame_kind      = msk_pkg::KIND_CREATE;
            res.out_frame_id    = msk_pkg::CREATE_ID;
            res.out_protocol    = cfg.socket_protocol;
            phase_next          = msk_pkg::PH_CREATE_WAIT;
          end
        end else if (phase == msk_pkg::PH_CONNECT) begin
          if (!socket_held) begin
            phase_next = msk_pkg::PH_READY;
          end else if (item.free_space >= {7'd0, cfg.connect_frame_size}) begin
            res.frame_kind   = msk_pkg::KIND_CONNECT;
            res.out_frame_id = msk_pkg::OTHER_ID;
            res.out_socket   = held_socket;
            res.out_port     = cfg.server_port;
            phase_next       = msk_pkg::PH_CONNECT_WAIT;
          end
        end else if (phase == msk_pkg::PH_CLOSE) begin
          if (!socket_held) begin
            phase_next = msk_pkg::PH_READY;
          end else if (item.free_space >= {8'd0, cfg.close_frame_size}) begin
            res.frame_kind   = msk_pkg::KIND_CLOSE;
            res.out_frame_id = msk_pkg::OTHER_ID;
            res.out_socket   = held_socket;
            phase_next       = msk_pkg::PH_CLOSE_WAIT;
          end
        end
      end
      msk_pkg::OP_CREATE_REPLY: begin
        if (phase == msk_pkg::PH_CREATE_WAIT &&
            item.reply_frame_id == msk_pkg::CREATE_ID) begin
          if (item.status_good) begin
            socket_held_next = 1'b1;
            held_socket_next = item.socket_number;
            phase_next       = msk_pkg::PH_CONNECT;
          end else begin
            socket_held_next = 1'b0;
            held_socket_next = 8'd0;
            phase_next       = msk_pkg::PH_READY;
          end
        end
      end
      msk_pkg::OP_CONNECT_REPLY: begin
        // a failed connect forces close from any phase
        if (held_match && !item.status_good) begin
          phase_next = msk_pkg::PH_CLOSE;
        end
      end
      msk_pkg::OP_SOCK_STATUS: begin
        if (held_match) begin
          if (!item.status_good) begin
            socket_held_next = 1'b0;
            held_socket_next = 8'd0;
          end
          phase_next = msk_pkg::PH_READY;
        end
      end
      msk_pkg::OP_CLOSE_REPLY: begin
        if (held_match && item.status_good) begin
          socket_held_next = 1'b0;
          held_socket_next = 8'd0;
          phase_next       = msk_pkg::PH_READY;
        end
      end
      msk_pkg::OP_MODEM_STATUS: begin
        network_flag_next = item.status_good;
      end
      msk_pkg::OP_AI_REPLY: begin
        if (item.command_is_ai && item.status_good && item.extra_length == 8'd1) begin
          network_flag_next = (item.assoc_byte == 8'd0);
        end
      end
      msk_pkg::OP_RECONNECT: begin
        if (phase == msk_pkg::PH_READY && socket_held) begin
          phase_next = msk_pkg::PH_CLOSE;
        end
      end
      default: ;
    endcase

    usable            = (phase_next == msk_pkg::PH_READY) && socket_held_next;
    res.frame_valid   = (res.frame_kind != msk_pkg::KIND_NONE);
    res.socket_usable = usable;
    res.usable_socket = usable ? held_socket_next : 8'd0;
    res.network_is_up = network_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= msk_pkg::PH_READY;
      socket_held    <= 1'b0;
      held_socket    <= 8'd0;
      network_flag   <= 1'b0;
      retry_deadline <= 32'd0;
    end else if (fire) begin
      phase          <= phase_next;
      socket_held    <= socket_held_next;
      held_socket    <= held_socket_next;
      network_flag   <= network_flag_next;
      retry_deadline <= retry_deadline_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase == msk_pkg::PH_READY || phase == msk_pkg::PH_CREATE_WAIT ||
    phase == msk_pkg::PH_CONNECT || phase == msk_pkg::PH_CONNECT_WAIT ||
    phase == msk_pkg::PH_CLOSE || phase == msk_pkg::PH_CLOSE_WAIT)
    else $error("phase left the six-phase sequence");

  a_empty_socket: assert property (@(posedge clk) disable iff (rst)
    !socket_held |-> held_socket == 8'd0)
    else $error("held socket number without a held socket");

  a_create_wait: assert property (@(posedge clk) disable iff (rst)
    fire && res.frame_kind == msk_pkg::KIND_CREATE
      |=> phase == msk_pkg::PH_CREATE_WAIT && !socket_held)
    else $error("create frame sent without entering create-wait");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(phase) && $stable(retry_deadline) && $stable(socket_held))
    else $error("state changed with no event");
`endif

endmodule

### hdl/modem_socket_keeper_core.sv
// Top level of the modem socket keeper: input register, state engine,
// result register and configuration port. Depends on msk_pkg, msk_regs
// and msk_engine.
`timescale 1ns / 1ps

// Takes one event request per clock while in_stall is low and returns exactly
// one result for each (the event sits in the input register, is evaluated
// against the socket state and lands in the result register). Sustained rate
// is one event per cycle while out_stall is low; the state update for an
// event completes in the same cycle it is evaluated, so back-to-back events
// see each other's effects. in_stall rises only when both the input register
// and the result register are full and out_stall is high. Configuration must
// be written while no event is in flight.
module modem_socket_keeper_core (
  input  logic                       clk,
  input  logic                       rst,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [msk_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // event channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 opcode,
  input  logic [7:0]                 reply_frame_id,
  input  logic [7:0]                 socket_number,
  input  logic                       status_good,
  input  logic                       command_is_ai,
  input  logic [7:0]                 extra_length,
  input  logic [7:0]                 assoc_byte,
  input  logic [15:0]                free_space,
  input  logic [31:0]                now_ms,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       frame_valid,
  output logic [1:0]                 frame_kind,
  output logic [7:0]                 out_frame_id,
  output logic [7:0]                 out_socket,
  output logic [15:0]                out_port,
  output logic [7:0]                 out_protocol,
  output logic                       socket_usable,
  output logic [7:0]                 usable_socket,
  output logic                       network_is_up
);

  msk_pkg::cfg_t    cfg;
  msk_pkg::item_t   item;
  msk_pkg::result_t res;
  msk_pkg::result_t res_q;
  logic             item_valid;
  logic             advance;
  logic             fire;
  logic             in_take;

  msk_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // result register frees up when empty or being taken
  assign advance  = !out_valid || !out_stall;
  assign fire     = item_valid && advance;
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.opcode         <= opcode;
      item.reply_frame_id <= reply_frame_id;
      item.socket_number  <= socket_number;
      item.status_good    <= status_good;
      item.command_is_ai  <= command_is_ai;
      item.extra_length   <= extra_length;
      item.assoc_byte     <= assoc_byte;
      item.free_space     <= free_space;
      item.now_ms         <= now_ms;
    end
  end

  msk_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign frame_valid   = res_q.frame_valid;
  assign frame_kind    = res_q.frame_kind;
  assign out_frame_id  = res_q.out_frame_id;
  assign out_socket    = res_q.out_socket;
  assign out_port      = res_q.out_port;
  assign out_protocol  = res_q.out_protocol;
  assign socket_usable = res_q.socket_usable;
  assign usable_socket = res_q.usable_socket;
  assign network_is_up = res_q.network_is_up;

`ifndef NO_ASSERTIONS
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    item_valid && !advance |=> item_valid && $stable(item))
    else $error("pending request lost while result register full");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res_q))
    else $error("stalled result changed");

  a_frame_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_valid == (frame_kind != msk_pkg::KIND_NONE))
    else $error("frame_valid disagrees with frame_kind");
`endif

endmodule

### test/modem_socket_keeper_core_tb.sv
// Self-checking testbench for modem_socket_keeper_core: directed event table, then
// model-guided random events under four register settings, with random stalls.
// Depends on msk_pkg and the modem_socket_keeper_core RTL.
`timescale 1ns / 1ps

module modem_socket_keeper_core_tb;

  localparam int HOLD_OFF_CYCLES = 80;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int PER_SETTING     = 106;

  localparam msk_pkg::result_t IDLE_DOWN = '0;
  localparam msk_pkg::result_t IDLE_UP   = {1'b0, msk_pkg::KIND_NONE, 8'd0, 8'd0, 16'd0,
                                            8'd0, 1'b0, 8'd0, 1'b1};
  localparam msk_pkg::result_t CREATE_UP = {1'b1, msk_pkg::KIND_CREATE, msk_pkg::CREATE_ID,
                                            8'd0, 16'd0, 8'd0, 1'b0, 8'd0, 1'b1};

  typedef struct {
    msk_pkg::item_t   ev;
    bit               typed;
    msk_pkg::result_t want;
  } script_row_t;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [msk_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       in_valid;
  logic                       in_stall;
  msk_pkg::item_t             req;
  logic                       out_valid;
  logic                       out_stall;
  logic                       frame_valid;
  logic [1:0]                 frame_kind;
  logic [7:0]                 out_frame_id;
  logic [7:0]                 out_socket;
  logic [15:0]                out_port;
  logic [7:0]                 out_protocol;
  logic                       socket_usable;
  logic [7:0]                 usable_socket;
  logic                       network_is_up;

  // Predictor copy of the socket state and the registers
  logic [2:0]    sk_phase = msk_pkg::PH_READY;
  logic          sk_held  = 1'b0;
  logic [7:0]    sk_num   = 8'd0;
  logic          net_up   = 1'b0;
  logic [31:0]   deadline = 32'd0;
  msk_pkg::cfg_t cfg      = {16'd0, 8'd0, 8'd0, 8'd0, 9'd0, 8'd0, msk_pkg::RETRY_RESET};

  msk_pkg::result_t due[$];
  script_row_t      script[$];
  int               mismatches     = 0;
  int               requests_sent  = 0;
  int               frames_by_kind[4];
  int               quiet          = 0;
  bit               tx_idling      = 1'b1;
  bit               rx_idling      = 1'b1;
  bit               hold_off_req   = 1'b0;

  modem_socket_keeper_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (req.opcode),
    .reply_frame_id(req.reply_frame_id),
    .socket_number (req.socket_number),
    .status_good   (req.status_good),
    .command_is_ai (req.command_is_ai),
    .extra_length  (req.extra_length),
    .assoc_byte    (req.assoc_byte),
    .free_space    (req.free_space),
    .now_ms        (req.now_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_valid   (frame_valid),
    .frame_kind    (frame_kind),
    .out_frame_id  (out_frame_id),
    .out_socket    (out_socket),
    .out_port      (out_port),
    .out_protocol  (out_protocol),
    .socket_usable (socket_usable),
    .usable_socket (usable_socket),
    .network_is_up (network_is_up)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies one event to the socket state and returns the report it yields
  function automatic msk_pkg::result_t advance_socket(msk_pkg::item_t it);
    msk_pkg::result_t r;
    logic             held_hit;
    r = '0;
    held_hit = sk_held && (sk_num == it.socket_number);
    case (it.opcode)
      msk_pkg::OP_POLL: begin
        case (sk_phase)
          msk_pkg::PH_READY: begin
            if (!sk_held && net_up && it.free_space >= {8'd0, cfg.create_frame_size} &&
                it.now_ms > deadline) begin
              deadline = it.now_ms + {16'd0, cfg.retry_interval_ms};
              r.frame_kind = msk_pkg::KIND_CREATE;
              r.out_frame_id = msk_pkg::CREATE_ID;
              r.out_protocol = cfg.socket_protocol;
              sk_phase = msk_pkg::PH_CREATE_WAIT;
            end
          end
          msk_pkg::PH_CONNECT: begin
            if (!sk_held) begin
              sk_phase = msk_pkg::PH_READY;
            end else if (it.free_space >= {7'd0, cfg.connect_frame_size}) begin
              r.frame_kind = msk_pkg::KIND_CONNECT;
              r.out_frame_id = msk_pkg::OTHER_ID;
              r.out_socket = sk_num;
              r.out_port = cfg.server_port;
              sk_phase = msk_pkg::PH_CONNECT_WAIT;
            end
          end
          msk_pkg::PH_CLOSE: begin
            if (!sk_held) begin
              sk_phase = msk_pkg::PH_READY;
            end else if (it.free_space >= {8'd0, cfg.close_frame_size}) begin
              r.frame_kind = msk_pkg::KIND_CLOSE;
              r.out_frame_id = msk_pkg::OTHER_ID;
              r.out_socket = sk_num;
              sk_phase = msk_pkg::PH_CLOSE_WAIT;
            end
          end
          default: ;
        endcase
      end
      msk_pkg::OP_CREATE_REPLY: begin
        if (sk_phase == msk_pkg::PH_CREATE_WAIT &&
            it.reply_frame_id == msk_pkg::CREATE_ID) begin
          sk_held = it.status_good;
          sk_num = it.status_good ? it.socket_number : 8'd0;
          sk_phase = it.status_good ? msk_pkg::PH_CONNECT : msk_pkg::PH_READY;
        end
      end
      msk_pkg::OP_CONNECT_REPLY: begin
        if (held_hit && !it.status_good) sk_phase = msk_pkg::PH_CLOSE;
      end
      msk_pkg::OP_SOCK_STATUS: begin
        if (held_hit) begin
          if (!it.status_good) begin
            sk_held = 1'b0;
            sk_num = 8'd0;
          end
          sk_phase = msk_pkg::PH_READY;
        end
      end
      msk_pkg::OP_CLOSE_REPLY: begin
        if (held_hit && it.status_good) begin
          sk_held = 1'b0;
          sk_num = 8'd0;
          sk_phase = msk_pkg::PH_READY;
        end
      end
      msk_pkg::OP_MODEM_STATUS: net_up = it.status_good;
      msk_pkg::OP_AI_REPLY: begin
        if (it.command_is_ai && it.status_good && it.extra_length == 8'd1)
          net_up = (it.assoc_byte == 8'd0);
      end
      default: begin
        if (sk_phase == msk_pkg::PH_READY && sk_held) sk_phase = msk_pkg::PH_CLOSE;
      end
    endcase
    r.frame_valid = (r.frame_kind != msk_pkg::KIND_NONE);
    r.socket_usable = (sk_phase == msk_pkg::PH_READY) && sk_held;
    r.usable_socket = r.socket_usable ? sk_num : 8'd0;
    r.network_is_up = net_up;
    return r;
  endfunction

  function automatic msk_pkg::item_t mk_item(logic [2:0] op, logic [7:0] rid,
                                             logic [7:0] sock, logic good, logic ai,
                                             logic [7:0] extra, logic [7:0] assoc,
                                             logic [15:0] space, logic [31:0] now);
    return {op, rid, sock, good, ai, extra, assoc, space, now};
  endfunction

  // Mostly well-formed events for the current phase, random content, some noise
  function automatic msk_pkg::item_t shape_event();
    msk_pkg::item_t it;
    logic [8:0]     need;
    it = msk_pkg::item_t'({$urandom, $urandom, $urandom});
    need = '0;
    if ($urandom_range(0, 4) == 0) return it;
    if (!net_up && $urandom_range(0, 3) != 0) begin
      it.opcode = ($urandom_range(0, 1) == 0) ? msk_pkg::OP_MODEM_STATUS
                                               : msk_pkg::OP_AI_REPLY;
      it.status_good = 1'b1;
      it.command_is_ai = 1'b1;
      it.extra_length = 8'd1;
      it.assoc_byte = 8'd0;
      return it;
    end
    case (sk_phase)
      msk_pkg::PH_READY: begin
        if (sk_held) begin
          case ($urandom_range(0, 7))
            0: it.opcode = msk_pkg::OP_RECONNECT;
            1: begin
              it.opcode = msk_pkg::OP_SOCK_STATUS;
              it.socket_number = sk_num;
            end
            2: begin
              it.opcode = msk_pkg::OP_CONNECT_REPLY;
              it.socket_number = sk_num;
            end
            3: it.opcode = msk_pkg::OP_MODEM_STATUS;
            default: it.opcode = msk_pkg::OP_POLL;
          endcase
        end else begin
          it.opcode = msk_pkg::OP_POLL;
          need = {1'b0, cfg.create_frame_size};
          // land on and just past the deadline
          it.now_ms = deadline + $urandom_range(0, 40);
        end
      end
      msk_pkg::PH_CREATE_WAIT: begin
        it.opcode = msk_pkg::OP_CREATE_REPLY;
        if ($urandom_range(0, 7) != 0) it.reply_frame_id = msk_pkg::CREATE_ID;
        it.status_good = ($urandom_range(0, 4) != 0);
      end
      msk_pkg::PH_CONNECT: begin
        it.opcode = msk_pkg::OP_POLL;
        need = cfg.connect_frame_size;
      end
      msk_pkg::PH_CLOSE: begin
        it.opcode = msk_pkg::OP_POLL;
        need = {1'b0, cfg.close_frame_size};
      end
      msk_pkg::PH_CONNECT_WAIT: begin
        it.opcode = ($urandom_range(0, 2) == 0) ? msk_pkg::OP_CONNECT_REPLY
                                                 : msk_pkg::OP_SOCK_STATUS;
        it.status_good = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 7) != 0) it.socket_number = sk_num;
      end
      default: begin
        it.opcode = ($urandom_range(0, 3) == 0) ? msk_pkg::OP_SOCK_STATUS
                                                 : msk_pkg::OP_CLOSE_REPLY;
        it.status_good = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 7) != 0) it.socket_number = sk_num;
      end
    endcase
    if (it.opcode == msk_pkg::OP_POLL && $urandom_range(0, 3) != 0)
      it.free_space = 16'(need + $urandom_range(0, 4) - 2);
    return it;
  endfunction

  task automatic add_row(msk_pkg::item_t ev, bit typed, msk_pkg::result_t want);
    script_row_t r;
    r.ev = ev;
    r.typed = typed;
    r.want = want;
    script.push_back(r);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      msk_pkg::REG_SERVER_PORT:    cfg.server_port = val[15:0];
      msk_pkg::REG_SOCKET_PROTO:   cfg.socket_protocol = val[7:0];
      msk_pkg::REG_HOST_LENGTH:    cfg.host_length = val[7:0];
      msk_pkg::REG_CREATE_SIZE:    cfg.create_frame_size = val[7:0];
      msk_pkg::REG_CONNECT_SIZE:   cfg.connect_frame_size = val[8:0];
      msk_pkg::REG_CLOSE_SIZE:     cfg.close_frame_size = val[7:0];
      msk_pkg::REG_RETRY_INTERVAL: cfg.retry_interval_ms = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(msk_pkg::cfg_t c);
    write_reg(msk_pkg::REG_SERVER_PORT, {16'd0, c.server_port});
    write_reg(msk_pkg::REG_SOCKET_PROTO, {24'd0, c.socket_protocol});
    write_reg(msk_pkg::REG_HOST_LENGTH, {24'd0, c.host_length});
    write_reg(msk_pkg::REG_CREATE_SIZE, {24'd0, c.create_frame_size});
    write_reg(msk_pkg::REG_CONNECT_SIZE, {23'd0, c.connect_frame_size});
    write_reg(msk_pkg::REG_CLOSE_SIZE, {24'd0, c.close_frame_size});
    write_reg(msk_pkg::REG_RETRY_INTERVAL, {16'd0, c.retry_interval_ms});
  endtask

  task automatic offer(msk_pkg::item_t ev, bit typed, msk_pkg::result_t want);
    int               gap;
    msk_pkg::result_t report;
    if (tx_idling && !hold_off_req && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= ev;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    report = advance_socket(ev);
    due.push_back(typed ? want : report);
    frames_by_kind[report.frame_kind]++;
    requests_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    msk_pkg::result_t got;
    msk_pkg::result_t want;
    if (out_valid && !out_stall) begin
      got = {frame_valid, frame_kind, out_frame_id, out_socket, out_port, out_protocol,
             socket_usable, usable_socket, network_is_up};
      if (due.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request outstanding: expected none, got %h",
                 $time, got);
      end else begin
        want = due.pop_front();
        compare_field("frame_valid", 32'(want.frame_valid), 32'(got.frame_valid));
        compare_field("frame_kind", 32'(want.frame_kind), 32'(got.frame_kind));
        compare_field("out_frame_id", 32'(want.out_frame_id), 32'(got.out_frame_id));
        compare_field("out_socket", 32'(want.out_socket), 32'(got.out_socket));
        compare_field("out_port", 32'(want.out_port), 32'(got.out_port));
        compare_field("out_protocol", 32'(want.out_protocol), 32'(got.out_protocol));
        compare_field("socket_usable", 32'(want.socket_usable), 32'(got.socket_usable));
        compare_field("usable_socket", 32'(want.usable_socket), 32'(got.usable_socket));
        compare_field("network_is_up", 32'(want.network_is_up), 32'(got.network_is_up));
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet == WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_off_req = 1'b0;
      end else if (rx_idling && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    msk_pkg::cfg_t c;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    req = '0;
    foreach (frames_by_kind[k]) frames_by_kind[k] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // network down: nothing moves, replies without a socket are ignored
    add_row(mk_item(msk_pkg::OP_POLL, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1'b1,
            IDLE_DOWN);
    add_row(mk_item(msk_pkg::OP_CREATE_REPLY, msk_pkg::CREATE_ID, 8'hFF, 1, 0, 0, 0, 0, 0),
            1'b1, IDLE_DOWN);
    add_row(mk_item(msk_pkg::OP_CONNECT_REPLY, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, IDLE_DOWN);
    add_row(mk_item(msk_pkg::OP_SOCK_STATUS, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, IDLE_DOWN);
    add_row(mk_item(msk_pkg::OP_CLOSE_REPLY, 0, 0, 1, 0, 0, 0, 0, 0), 1'b1, IDLE_DOWN);
    add_row(mk_item(msk_pkg::OP_RECONNECT, 0, 0, 1, 0, 0, 0, 0, 0), 1'b1, IDLE_DOWN);
    // association reply only counts with exactly one data byte
    add_row(mk_item(msk_pkg::OP_AI_REPLY, 0, 0, 1, 1, 8'd1, 8'd0, 0, 0), 1'b1, IDLE_UP);
    add_row(mk_item(msk_pkg::OP_AI_REPLY, 0, 0, 1, 1, 8'hFF, 8'hFF, 0, 0), 1'b1, IDLE_UP);
    add_row(mk_item(msk_pkg::OP_AI_REPLY, 0, 0, 1, 1, 8'd1, 8'h80, 0, 0), 1'b1,
            IDLE_DOWN);
    add_row(mk_item(msk_pkg::OP_MODEM_STATUS, 0, 0, 1, 0, 0, 0, 0, 0), 1'b1, IDLE_UP);
    // deadline 0: time 0 is not past it; max time is, and the new deadline wraps
    add_row(mk_item(msk_pkg::OP_POLL, 0, 0, 0, 0, 0, 0, 16'hFFFF, 32'd0), 1'b1, IDLE_UP);
    add_row(mk_item(msk_pkg::OP_POLL, 0, 0, 0, 0, 0, 0, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
            CREATE_UP);
    add_row(mk_item(msk_pkg::OP_CREATE_REPLY, 8'd74, 8'd3, 1, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_item(msk_pkg::OP_CREATE_REPLY, msk_pkg::CREATE_ID, 8'd3, 0, 0, 0, 0, 0, 0),
            1'b0, '0);
    add_row(mk_item(msk_pkg::OP_POLL, 0, 0, 0, 0, 0, 0, 0, 32'd2999), 1'b0, '0);
    add_row(mk_item(msk_pkg::OP_POLL, 0, 0, 0, 0, 0, 0, 0, 32'd3000), 1'b0, '0);
    add_row(mk_item(msk_pkg::OP_CREATE_REPLY, msk_pkg::CREATE_ID, 8'hFF, 1, 0, 0, 0, 0, 0),
            1'b0, '0);
    add_row(mk_item(msk_pkg::OP_POLL, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_item(msk_pkg::OP_POLL, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_item(msk_pkg::OP_SOCK_STATUS, 0, 8'hFF, 1, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_item(msk_pkg::OP_RECONNECT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_item(msk_pkg::OP_POLL, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_item(msk_pkg::OP_CLOSE_REPLY, 0, 8'd0, 1, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_item(msk_pkg::OP_CLOSE_REPLY, 0, 8'hFF, 1, 0, 0, 0, 0, 0), 1'b0, '0);
    // failed connect reply forces close from whatever phase
    add_row(mk_item(msk_pkg::OP_POLL, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1'b0, '0);
    add_row(mk_item(msk_pkg::OP_CREATE_REPLY, msk_pkg::CREATE_ID, 8'd0, 1, 0, 0, 0, 0, 0),
            1'b0, '0);
    add_row(mk_item(msk_pkg::OP_CONNECT_REPLY, 0, 8'd0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_item(msk_pkg::OP_SOCK_STATUS, 0, 8'd0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_item(msk_pkg::OP_MODEM_STATUS, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    foreach (script[i]) offer(script[i].ev, script[i].typed, script[i].want);

    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: c = '0;
        1: c = {16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 9'h1FF, 8'hFF, 16'hFFFF};
        2: c = msk_pkg::cfg_t'({$urandom, $urandom, $urandom});
        default: begin
          c = msk_pkg::cfg_t'({$urandom, $urandom, $urandom});
          c.create_frame_size = 8'($urandom_range(0, 15));
          c.connect_frame_size = 9'($urandom_range(0, 15));
          c.close_frame_size = 8'($urandom_range(0, 15));
          tx_idling = 1'b0;
          rx_idling = 1'b0;
        end
      endcase
      load_settings(c);
      for (int n = 0; n < PER_SETTING; n++) begin
        // long receiver hold-off so the core backs up into in_stall
        if (p == 1 && n == 20) hold_off_req = 1'b1;
        offer(shape_event(), 1'b0, '0);
      end
    end
    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d event requests: directed table, then four register settings",
             requests_sent);
    $display("from all-zero to all-max, with %0d create, %0d connect, %0d close frames.",
             frames_by_kind[msk_pkg::KIND_CREATE], frames_by_kind[msk_pkg::KIND_CONNECT],
             frames_by_kind[msk_pkg::KIND_CLOSE]);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

### filelist.f
hdl/msk_pkg.sv
hdl/msk_regs.sv
hdl/msk_engine.sv
hdl/modem_socket_keeper_core.sv
test/modem_socket_keeper_core_tb.sv
